FILE: hdl/ird_pkg.sv
// ----------------------------------------------------------------------------
// ird_pkg
// shared types and codes for the indexed ring deque
// ----------------------------------------------------------------------------
package ird_pkg;

   // operation codes, three bits on the request word
   typedef enum logic [2:0] {
      OP_GET    = 3'd0,
      OP_PUT    = 3'd1,
      OP_INSERT = 3'd2,
      OP_REMOVE = 3'd3,
      OP_ROTATE = 3'd4
   } op_type;

   // status codes on the response word
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_BAD   = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_TARGET,
      S_MOVE_RD,
      S_MOVE_WR,
      S_STORE,
      S_FINISH,
      S_RESPOND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // latch request fields
      logic decode;    // register checks and move plan
      logic take;      // read the addressed element into the result holder
      logic move_rd;   // read the element being moved
      logic move_wr;   // write it to its new place, step the move counters
      logic store;     // write the request data at the target
      logic finish;    // update count or head
      logic respond;   // load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] op;
      logic       skip;       // error status or unknown code: nothing to do
      logic       rem_zero;   // no element left to move
      logic       slot_free;  // response register can take a word
   } flags_type;

endpackage

FILE: hdl/indexed_ring_deque.sv
// ----------------------------------------------------------------------------
// indexed_ring_deque
// bounded ordered sequence of words with get, put, insert, remove, rotate
// ----------------------------------------------------------------------------
// The block keeps up to CAPACITY words, index 0 at the head, in a single-port
// memory used as a circular buffer behind a head pointer. One request word is
// taken at a time and gives exactly one response word. After decode, get,
// put and remove read the target, put then writes it, and insert, remove
// and rotate spend a read and a write state on each element they move:
// insert shifts the elements from the gap to the tail up by one, remove
// shifts the elements after the index down by one, and rotate copies the
// elements ahead of the new head behind the tail and then moves the head
// pointer. The one memory port (one read or one write a cycle) is why each
// moved element needs both states. Errors (bad index, position or amount,
// empty, full) leave the store alone and return a zero data field; unknown
// operation codes return status ok with nothing changed. A new request is
// taken while the last response still waits in its output register.
module indexed_ring_deque #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,

   // request words
   input  logic req_tvalid,
   output logic req_tready,
   // operation, item_index, insert_position, rotate_amount, data_in
   input  logic [((3 + $clog2(CAPACITY) + $clog2(CAPACITY + 2) + 1 + $clog2(CAPACITY + 1) + 1
                  + DATA_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,

   // response words
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // data_out, count, status
   output logic [((DATA_WIDTH + $clog2(CAPACITY + 1) + 2 + 7) / 8) * 8 - 1:0] rsp_tdata
);
   import ird_pkg::*;

   localparam int AW = $clog2(CAPACITY);          // item_index width
   localparam int CW = $clog2(CAPACITY + 1);      // count width
   localparam int PW = $clog2(CAPACITY + 2) + 1;  // insert_position width
   localparam int RW = $clog2(CAPACITY + 1) + 1;  // rotate_amount width
   localparam int RSP_TW = ((DATA_WIDTH + CW + 2 + 7) / 8) * 8;

   // bit offsets of the request fields
   localparam int IDX_LO = 3;
   localparam int POS_LO = IDX_LO + AW;
   localparam int ROT_LO = POS_LO + PW;
   localparam int DIN_LO = ROT_LO + RW;

   cmd_type               cmd;
   flags_type             flags;
   logic [DATA_WIDTH-1:0] data_out;
   logic [CW-1:0]         count_out;
   status_type            status_out;

   // sequencer
   ird_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   // store, checks and response register
   ird_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW),
      .CW         (CW),
      .PW         (PW),
      .RW         (RW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .flags      (flags),
      .op_in      (req_tdata[2:0]),
      .idx_in     (req_tdata[IDX_LO +: AW]),
      .pos_in     (signed'(req_tdata[POS_LO +: PW])),
      .rot_in     (signed'(req_tdata[ROT_LO +: RW])),
      .din_in     (req_tdata[DIN_LO +: DATA_WIDTH]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .data_out   (data_out),
      .count_out  (count_out),
      .status_out (status_out)
   );

   // pack the response word, data in the low bits, zero fill at the top
   assign rsp_tdata = RSP_TW'({status_out, count_out, data_out});

endmodule

FILE: hdl/ird_ctrl.sv
// ----------------------------------------------------------------------------
// ird_ctrl
// sequencer for the ring deque: steps one request through its states
// ----------------------------------------------------------------------------
module ird_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  ird_pkg::flags_type flags,
   output ird_pkg::cmd_type   cmd
);
   import ird_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (flags.skip) begin
               state_in = S_RESPOND;
            end else if (flags.op == OP_INSERT || flags.op == OP_ROTATE) begin
               state_in = S_MOVE_RD;
            end else begin
               state_in = S_TARGET;
            end
         end
         S_TARGET: begin
            if (flags.op == OP_GET) begin
               state_in = S_RESPOND;
            end else if (flags.op == OP_PUT) begin
               state_in = S_STORE;
            end else begin
               state_in = S_MOVE_RD;
            end
         end
         S_MOVE_RD: begin
            if (!flags.rem_zero) begin
               state_in = S_MOVE_WR;
            end else if (flags.op == OP_INSERT) begin
               state_in = S_STORE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_MOVE_WR: begin
            state_in = S_MOVE_RD;
         end
         S_STORE: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in = S_RESPOND;
         end
         S_RESPOND: begin
            if (flags.slot_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
         end
         S_TARGET: begin
            cmd.take = 1'b1;
         end
         S_MOVE_RD: begin
            cmd.move_rd = !flags.rem_zero;
         end
         S_MOVE_WR: begin
            cmd.move_wr = 1'b1;
         end
         S_STORE: begin
            cmd.store = 1'b1;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
         end
         S_RESPOND: begin
            cmd.respond = flags.slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: hdl/ird_datapath.sv
// ----------------------------------------------------------------------------
// ird_datapath
// element store as a circular buffer with head pointer, checks, move
// counters and response register
// ----------------------------------------------------------------------------
module ird_datapath #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = $clog2(CAPACITY),
   parameter int CW         = $clog2(CAPACITY + 1),
   parameter int PW         = $clog2(CAPACITY + 2) + 1,
   parameter int RW         = $clog2(CAPACITY + 1) + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ird_pkg::cmd_type       cmd,
   output ird_pkg::flags_type     flags,
   input  logic [2:0]             op_in,
   input  logic [AW-1:0]          idx_in,
   input  logic signed [PW-1:0]   pos_in,
   input  logic signed [RW-1:0]   rot_in,
   input  logic [DATA_WIDTH-1:0]  din_in,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [DATA_WIDTH-1:0]  data_out,
   output logic [CW-1:0]          count_out,
   output ird_pkg::status_type    status_out
);
   import ird_pkg::*;

   localparam int LW = AW + 1;   // logical offsets reach below twice the depth
   localparam int EW = PW + 2;   // signed width for the range checks

   // request fields
   logic [2:0]            op_ff, op_in_r;
   logic [AW-1:0]         idx_ff, idx_in_r;
   logic signed [PW-1:0]  pos_ff, pos_in_r;
   logic signed [RW-1:0]  rot_ff, rot_in_r;
   logic [DATA_WIDTH-1:0] din_ff, din_in_r;

   // plan and ring state
   status_type            status_ff, status_in;
   logic [LW-1:0]         target_ff, target_in;
   logic [LW-1:0]         cur_ff, cur_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;
   status_type            rsp_status_ff, rsp_status_in;

   // memory and its read registers
   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_ff;
   logic [DATA_WIDTH-1:0] keep_ff;

   // decode results
   logic signed [EW-1:0]  n_e, idx_e, pos_e, rot_e, at_e, start_e;
   logic signed [EW-1:0]  tgt_e, cur_e, rem_e;
   status_type            st_dec;
   logic                  known_op;

   // address path
   logic [LW-1:0]         dst_log, addr_log, l1, sum_log;
   logic [AW-1:0]         mem_addr;
   logic                  wr_en;
   logic [DATA_WIDTH-1:0] wr_data;

   // checks and move plan from the latched request
   always_comb begin
      n_e     = signed'(EW'(count_ff));
      idx_e   = signed'(EW'(idx_ff));
      pos_e   = EW'(pos_ff);
      rot_e   = EW'(rot_ff);
      at_e    = (pos_e > 0) ? pos_e - EW'(1) : pos_e + n_e;
      start_e = (rot_e >= 0) ? ((rot_e == n_e) ? EW'(0) : rot_e) : rot_e + n_e;
      st_dec  = STAT_OK;
      known_op = 1'b1;
      tgt_e   = idx_e;
      cur_e   = idx_e + EW'(1);
      rem_e   = n_e - EW'(1) - idx_e;
      case (op_ff)
         OP_GET, OP_PUT, OP_REMOVE: begin
            if (count_ff == '0) begin
               st_dec = STAT_EMPTY;
            end else if (idx_e >= n_e) begin
               st_dec = STAT_BAD;
            end
         end
         OP_INSERT: begin
            tgt_e = at_e;
            cur_e = n_e - EW'(1);
            rem_e = n_e - at_e;
            if (pos_e < -n_e || pos_e > n_e + EW'(1)) begin
               st_dec = STAT_BAD;
            end else if (count_ff == CW'(CAPACITY)) begin
               st_dec = STAT_FULL;
            end
         end
         OP_ROTATE: begin
            tgt_e = start_e;
            cur_e = '0;
            rem_e = start_e;
            if (count_ff == '0) begin
               st_dec = STAT_EMPTY;
            end else if (rot_e > n_e || rot_e < -n_e) begin
               st_dec = STAT_BAD;
            end
         end
         default: begin
            known_op = 1'b0;
         end
      endcase
   end

   // logical to physical slot: (head + offset) modulo depth
   always_comb begin
      if (op_ff == OP_INSERT) begin
         dst_log = cur_ff + LW'(1);
      end else if (op_ff == OP_REMOVE) begin
         dst_log = cur_ff - LW'(1);
      end else begin
         dst_log = cur_ff + LW'(count_ff);
      end
      if (cmd.move_rd) begin
         addr_log = cur_ff;
      end else if (cmd.move_wr) begin
         addr_log = dst_log;
      end else begin
         addr_log = target_ff;
      end
      l1       = (addr_log >= LW'(CAPACITY)) ? addr_log - LW'(CAPACITY) : addr_log;
      sum_log  = LW'(head_ff) + l1;
      mem_addr = (sum_log >= LW'(CAPACITY)) ? AW'(sum_log - LW'(CAPACITY))
                                            : AW'(sum_log);
   end

   assign wr_en   = cmd.move_wr || cmd.store;
   assign wr_data = cmd.store ? din_ff : rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[mem_addr] <= wr_data;
      if (cmd.move_rd) rd_ff <= mem[mem_addr];
      if (cmd.take) keep_ff <= mem[mem_addr];
   end

   // next values
   always_comb begin
      op_in_r       = op_ff;
      idx_in_r      = idx_ff;
      pos_in_r      = pos_ff;
      rot_in_r      = rot_ff;
      din_in_r      = din_ff;
      status_in     = status_ff;
      target_in     = target_ff;
      cur_in        = cur_ff;
      rem_in        = rem_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.load) begin
         op_in_r  = op_in;
         idx_in_r = idx_in;
         pos_in_r = pos_in;
         rot_in_r = rot_in;
         din_in_r = din_in;
      end
      if (cmd.decode) begin
         status_in = st_dec;
         target_in = tgt_e[LW-1:0];
         cur_in    = cur_e[LW-1:0];
         rem_in    = rem_e[CW-1:0];
      end
      if (cmd.move_wr) begin
         cur_in = (op_ff == OP_INSERT) ? cur_ff - LW'(1) : cur_ff + LW'(1);
         rem_in = rem_ff - CW'(1);
      end
      if (cmd.finish) begin
         if (op_ff == OP_INSERT) begin
            count_in = count_ff + CW'(1);
         end else if (op_ff == OP_REMOVE) begin
            count_in = count_ff - CW'(1);
         end else if (op_ff == OP_ROTATE) begin
            head_in = mem_addr;
         end
      end
      if (cmd.respond) begin
         rsp_valid_in  = 1'b1;
         rsp_count_in  = count_ff;
         rsp_status_in = status_ff;
         if (status_ff != STAT_OK) begin
            rsp_data_in = '0;
         end else if (op_ff == OP_GET || op_ff == OP_PUT || op_ff == OP_REMOVE) begin
            rsp_data_in = keep_ff;
         end else if (op_ff == OP_INSERT) begin
            rsp_data_in = din_ff;
         end else begin
            rsp_data_in = '0;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in_r;
      idx_ff        <= idx_in_r;
      pos_ff        <= pos_in_r;
      rot_ff        <= rot_in_r;
      din_ff        <= din_in_r;
      status_ff     <= status_in;
      target_ff     <= target_in;
      cur_ff        <= cur_in;
      rem_ff        <= rem_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign flags.op        = op_ff;
   assign flags.skip      = (st_dec != STAT_OK) || !known_op;
   assign flags.rem_zero  = (rem_ff == '0);
   assign flags.slot_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign data_out   = rsp_data_ff;
   assign count_out  = rsp_count_ff;
   assign status_out = rsp_status_ff;

endmodule
